@@ hw/rtl/cbjq_pkg.sv @@
// Shared types and constants for the coalescing batch job queue.
// Used by the front end, the back end and the top level; no dependencies.

package cbjq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int HANDLER_BITS = 8;
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CFG_W        = 5;
	localparam int CMP_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	typedef enum logic [1:0] {
		FN_PUSH = 2'd0,
		FN_PULL = 2'd1,
		FN_STOP = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_PUSHED    = 3'd1,
		ST_COALESCED = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_STOPPED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] item_id;
		logic [7:0]  handler;
		logic [31:0] cookie;
	} job_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_item_id;
		logic [7:0]  out_handler;
		logic [31:0] out_cookie;
		logic        last;
	} res_t;

	typedef struct packed {
		func_t                   op;
		logic [31:0]             item_id;
		logic [HANDLER_BITS-1:0] handler;
		logic [31:0]             cookie;
	} cmd_t;

	typedef enum logic [1:0] {
		BE_IDLE  = 2'd0,
		BE_EXEC  = 2'd1,
		BE_DRAIN = 2'd2
	} be_state_t;

endpackage

@@ hw/rtl/cbjq_front.sv @@
// Front end: accepts input items, drops unused operations, and queues commands.
// Depends on cbjq_pkg for the item and command types.

module cbjq_front
	import cbjq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  job_valid,
	output logic  job_stall,
	input  job_t  job,
	output logic  cmd_valid,
	input  logic  cmd_pop,
	output cmd_t  cmd
);

	localparam int FQ_DEPTH = 2;

	cmd_t       fifo_q [FQ_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       pop;
	cmd_t       cmd_d;

	assign job_stall = (cnt_q == 2'(FQ_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign pop       = cmd_pop && cmd_valid;

	always_comb begin
		keep = job_valid && !job_stall;
		case (job.func)
			FN_PUSH: cmd_d.op = FN_PUSH;
			FN_PULL: cmd_d.op = FN_PULL;
			FN_STOP: cmd_d.op = FN_STOP;
			default: begin
				cmd_d.op = FN_NONE;
				keep     = 1'b0;
			end
		endcase
		cmd_d.item_id = job.item_id;
		cmd_d.handler = job.handler[HANDLER_BITS-1:0];
		cmd_d.cookie  = job.cookie;
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			fifo_q[wr_ptr_q] <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (keep) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({keep, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/cbjq_back.sv @@
// Back end: holds the job store, matches pushes, drains pulls and registers results.
// Depends on cbjq_pkg for the command, result and state types.

module cbjq_back
	import cbjq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  cmd_t             cmd,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res
);

	be_state_t               state_q, state_d;
	cmd_t                    cmd_q;
	logic [31:0]             ids_q [QUEUE_DEPTH];
	logic [HANDLER_BITS-1:0] hds_q [QUEUE_DEPTH];
	logic [31:0]             cks_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]        fill_q, fill_d;
	logic                    stop_q, stop_d;
	logic [CFG_W-1:0]        cap_q;
	logic [IDX_W-1:0]        idx_q, idx_d;
	res_t                    res_q, res_d;
	logic                    res_valid_q;
	logic                    res_load;
	logic                    wr_en;
	logic                    slot_free;
	logic [QUEUE_DEPTH-1:0]  hit;
	logic                    any_hit;
	logic [CMP_W-1:0]        lim;
	logic                    full;
	logic                    drain_last;
	res_t                    drain_res;

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign slot_free = !res_valid_q || !res_stall;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			hit[i] = (CNT_W'(i) < fill_q) && (ids_q[i] == cmd_q.item_id) &&
				(hds_q[i] == cmd_q.handler) && (cks_q[i] == cmd_q.cookie);
		end
		any_hit = |hit;
		lim     = (CMP_W'(cap_q) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
			: CMP_W'(cap_q);
		full    = (CMP_W'(fill_q) >= lim);

		drain_last            = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
		drain_res.status      = ST_DELIVERED;
		drain_res.out_item_id = ids_q[idx_q];
		drain_res.out_handler = 8'(hds_q[idx_q]);
		drain_res.out_cookie  = cks_q[idx_q];
		drain_res.last        = drain_last;
	end

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		stop_d   = stop_q;
		idx_d    = idx_q;
		cmd_pop  = 1'b0;
		res_load = 1'b0;
		wr_en    = 1'b0;
		res_d    = '{status: ST_EMPTY, out_item_id: '0, out_handler: '0,
			out_cookie: '0, last: 1'b1};
		case (state_q)
			BE_IDLE: begin
				idx_d = '0;
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = BE_EXEC;
				end
			end
			BE_EXEC: begin
				case (cmd_q.op)
					FN_PUSH: begin
						if (slot_free) begin
							res_load = 1'b1;
							state_d  = BE_IDLE;
							if (any_hit) begin
								res_d.status = ST_COALESCED;
							end else if (full) begin
								res_d.status = ST_FULL;
							end else begin
								res_d.status = ST_PUSHED;
								wr_en        = 1'b1;
								fill_d       = fill_q + CNT_W'(1);
							end
						end
					end
					FN_PULL: begin
						if (slot_free) begin
							res_load = 1'b1;
							if (stop_q) begin
								res_d.status = ST_STOPPED;
								fill_d       = '0;
								state_d      = BE_IDLE;
							end else if (fill_q == '0) begin
								res_d.status = ST_EMPTY;
								state_d      = BE_IDLE;
							end else begin
								res_d = drain_res;
								if (drain_last) begin
									fill_d  = '0;
									state_d = BE_IDLE;
								end else begin
									idx_d   = idx_q + IDX_W'(1);
									state_d = BE_DRAIN;
								end
							end
						end
					end
					default: begin
						stop_d  = 1'b1;
						state_d = BE_IDLE;
					end
				endcase
			end
			BE_DRAIN: begin
				if (slot_free) begin
					res_load = 1'b1;
					res_d    = drain_res;
					if (drain_last) begin
						fill_d  = '0;
						state_d = BE_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = BE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (wr_en) begin
			ids_q[fill_q[IDX_W-1:0]] <= cmd_q.item_id;
			hds_q[fill_q[IDX_W-1:0]] <= cmd_q.handler;
			cks_q[fill_q[IDX_W-1:0]] <= cmd_q.cookie;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			fill_q      <= '0;
			stop_q      <= 1'b0;
			idx_q       <= '0;
			cap_q       <= CAP_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			stop_q  <= stop_d;
			idx_q   <= idx_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/coalescing_batch_job_queue.sv @@
// Top level of the coalescing batch job queue: front end, command queue, back end.
// Depends on cbjq_pkg, cbjq_front and cbjq_back.
//
//   channel  direction  handshake             payload
//   job      in         job_valid/job_stall   job_t (func, item_id, handler, cookie)
//   res      out        res_valid/res_stall   res_t (status, job fields, last)
//   cfg      in         cfg_valid/cfg_ready   capacity limit, 5 bits
//
// In the back end a push is taken from the queue in IDLE and matched in EXEC against all
// stored jobs in parallel. A pull delivers the stored jobs one result at a time, in EXEC
// then DRAIN, set by the single read port of the job store; a stop sets the stop flag.
// Reset clears the counts, the stop flag and the queue; the store itself is not cleared.
// A stalled result holds in its output register while the two-entry queue keeps taking items until full.

module coalescing_batch_job_queue
	import cbjq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_stall,
	input  job_t             job,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	cbjq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_stall (job_stall),
		.job       (job),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	cbjq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
